// ----- rtl/core/mhmt_pkg.sv -----
package mhmt_pkg;

    // Default number of compare slots
    localparam int MAX_HARTS_DEF = 8;

    // Transaction codes carried in func
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Timer region map
    localparam logic [14:0] CMP_END      = 15'h7FF8;
    localparam int          HALF_SEL_BIT = 2;

    // Configuration register indexes
    localparam logic REG_ACTIVE_HARTS = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] address;
        logic [31:0] write_data;
    } cmd_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fault;
        logic [7:0]  timer_pending;
        logic [63:0] earliest_compare;
    } result_t;

    // Select one 32-bit half of a 64-bit register
    function automatic logic [31:0] pick_half(input logic [63:0] v, input logic hi);
        logic [31:0] r;
        r = hi ? v[63:32] : v[31:0];
        return r;
    endfunction

    // Replace one 32-bit half of a 64-bit register, keep the other
    function automatic logic [63:0] merge_half(input logic [63:0] old,
                                               input logic        hi,
                                               input logic [31:0] val);
        logic [63:0] r;
        r = hi ? {val, old[31:0]} : {old[63:32], val};
        return r;
    endfunction

endpackage

// ----- rtl/core/multi_hart_machine_timer.sv -----
// Channel    | Ports                                  | Transaction taken when
// -----------+----------------------------------------+------------------------------
// command    | start, busy, cmd                       | start && !busy
// result     | done, result                           | done (one cycle, no stall)
// config APB | psel penable pwrite paddr pwdata       | psel && penable && pwrite
//            | prdata pready                          |   && pready
//
// A command passes from acceptance to its done strobe through the slot read,
// the update, then one shared 64-bit compare step per hart slot reading the
// compare memory one entry a cycle. An active_harts write starts the same
// per-hart scan, with busy high and no result. Reset puts the counter at
// zero, active_harts at one and marks every compare slot as all ones through
// its valid bit.
// The receiver cannot stall; busy rises for the whole of each transaction.
module multi_hart_machine_timer #(
    parameter int MAX_HARTS = mhmt_pkg::MAX_HARTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mhmt_pkg::cmd_t   cmd,
    output logic             done,
    output mhmt_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int HART_W = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
    localparam int CNT_W  = $clog2(MAX_HARTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCESS = 4'b0010,
        ST_MERGE  = 4'b0100,
        ST_SCAN   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    mhmt_pkg::cmd_t     cmd_reg;
    mhmt_pkg::result_t  result_reg;
    logic               done_reg;
    logic               emit_reg;
    logic [63:0]        time_reg, time_next;
    logic [3:0]         active_harts_reg;
    logic [31:0]        rdata_reg, rdata_next;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               chk_vld_reg;
    logic [HART_W-1:0]  chk_idx_reg;
    logic [7:0]         pend_reg, pend_next;
    logic [63:0]        min_acc_reg, min_next;

    // Compare memory with per-entry valid bits
    logic [63:0]        mem [MAX_HARTS];
    logic [MAX_HARTS-1:0] valid_reg;
    logic [63:0]        mem_q_reg;
    logic               vld_q_reg;
    logic [HART_W-1:0]  rd_addr;
    logic               mem_we;
    logic [63:0]        mem_wdata;

    logic               accept;
    logic               cfg_hit;
    logic [3:0]         act_cnt;
    logic [11:0]        slot;
    logic               slot_active;
    logic               in_cmp;
    logic               hi_sel;
    logic [63:0]        cmp_eff;
    logic               hart_on;
    logic               hit;
    logic               lower;
    logic               scan_last;

    assign pready  = 1'b1;
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign cfg_hit = psel && penable && pwrite && pready
                     && (paddr[2] == mhmt_pkg::REG_ACTIVE_HARTS);
    assign prdata  = (paddr[2] == mhmt_pkg::REG_ACTIVE_HARTS)
                     ? {28'd0, active_harts_reg} : 32'd0;
    assign done    = done_reg;
    assign result  = result_reg;

    // Saturate the active count to the slot count
    assign act_cnt = (active_harts_reg > 4'(MAX_HARTS)) ? 4'(MAX_HARTS)
                                                         : active_harts_reg;

    // Decode the latched address
    assign slot        = cmd_reg.address[14:3];
    assign slot_active = slot < {8'd0, act_cnt};
    assign in_cmp      = cmd_reg.address < mhmt_pkg::CMP_END;
    assign hi_sel      = cmd_reg.address[mhmt_pkg::HALF_SEL_BIT];

    // Entries never written read as all ones
    assign cmp_eff = vld_q_reg ? mem_q_reg : '1;

    // Pick the memory read address
    always_comb
    begin
        if (state_reg == ST_SCAN)
            rd_addr = scan_cnt_reg[HART_W-1:0];
        else
            rd_addr = slot[HART_W-1:0];
    end

    // Apply the access in the update cycle
    always_comb
    begin
        rdata_next = 32'd0;
        time_next  = time_reg;
        mem_we     = 1'b0;
        mem_wdata  = mhmt_pkg::merge_half(cmp_eff, hi_sel, cmd_reg.write_data);
        if (state_reg == ST_MERGE)
        begin
            case (cmd_reg.func)
                mhmt_pkg::FUNC_TICK:
                    time_next = time_reg + 64'd1;
                mhmt_pkg::FUNC_READ:
                begin
                    if (in_cmp)
                    begin
                        if (slot_active)
                            rdata_next = mhmt_pkg::pick_half(cmp_eff, hi_sel);
                    end
                    else
                        rdata_next = mhmt_pkg::pick_half(time_reg, hi_sel);
                end
                mhmt_pkg::FUNC_WRITE:
                begin
                    if (in_cmp)
                        mem_we = slot_active;
                    else
                        time_next = mhmt_pkg::merge_half(time_reg, hi_sel,
                                                         cmd_reg.write_data);
                end
                default:
                    ;
            endcase
        end
    end

    // Shared compare step: one hart slot per cycle
    assign hart_on   = 4'(chk_idx_reg) < act_cnt;
    assign hit       = chk_vld_reg && hart_on && (time_reg >= cmp_eff);
    assign lower     = chk_vld_reg && hart_on && (cmp_eff < min_acc_reg);
    assign pend_next = pend_reg | (hit ? (8'd1 << chk_idx_reg) : 8'd0);
    assign min_next  = lower ? cmp_eff : min_acc_reg;
    assign scan_last = (scan_cnt_reg == CNT_W'(MAX_HARTS));

    // Sequence the transaction
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ACCESS;
                else if (cfg_hit)
                    state_next = ST_SCAN;
            end
            ST_ACCESS:
                state_next = ST_MERGE;
            ST_MERGE:
                state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            done_reg         <= 1'b0;
            emit_reg         <= 1'b0;
            time_reg         <= 64'd0;
            active_harts_reg <= 4'd1;
            scan_cnt_reg     <= '0;
            chk_vld_reg      <= 1'b0;
            valid_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            time_reg  <= time_next;
            if (cfg_hit)
                active_harts_reg <= pwdata[3:0];
            if (mem_we)
                valid_reg[slot[HART_W-1:0]] <= 1'b1;
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    chk_vld_reg  <= 1'b0;
                    emit_reg     <= accept;
                end
                ST_ACCESS:
                    ;
                ST_MERGE:
                begin
                    scan_cnt_reg <= '0;
                    chk_vld_reg  <= 1'b0;
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    chk_vld_reg  <= !scan_last;
                    if (scan_last)
                        done_reg <= emit_reg;
                end
                default:
                    ;
            endcase
        end
    end

    // Payload registers and compare memory
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_addr];
        vld_q_reg <= valid_reg[rd_addr];
        if (mem_we)
            mem[slot[HART_W-1:0]] <= mem_wdata;
        chk_idx_reg <= scan_cnt_reg[HART_W-1:0];
        if (accept)
            cmd_reg <= cmd;
        if (state_reg == ST_MERGE)
            rdata_reg <= rdata_next;
        if (state_reg == ST_SCAN)
        begin
            pend_reg    <= pend_next;
            min_acc_reg <= min_next;
        end
        else
        begin
            pend_reg    <= 8'd0;
            min_acc_reg <= '1;
        end
        if ((state_reg == ST_SCAN) && scan_last)
        begin
            result_reg.read_data        <= rdata_reg;
            result_reg.fault            <= 1'b0;
            result_reg.timer_pending    <= pend_next;
            result_reg.earliest_compare <= min_next;
        end
    end

    // Checks
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.fault == 1'b0))
        else $error("fault inside the timer region");

    a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.timer_pending >> act_cnt) == 8'd0))
        else $error("pending bit set for an inactive hart");

endmodule
